// ----- rtl/core/monotone_cubic_tangents_defines.svh -----
// Assertion shorthands for the monotone cubic tangent block.
`ifndef MONOTONE_CUBIC_TANGENTS_DEFINES_SVH
`define MONOTONE_CUBIC_TANGENTS_DEFINES_SVH

// Check on every clock edge outside reset.
`define MCT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MCT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/mct_pkg.sv -----
package mct_pkg;

   localparam int MAX_POINTS = 256;
   localparam int FRAC_BITS  = 16;

   localparam int CNT_W  = $clog2(MAX_POINTS);
   localparam int IDX_W  = 8;
   localparam int VAL_W  = 17;
   localparam int SPAN_W = VAL_W + 1;
   localparam int TAN_W  = 34;

   // interior datapath widths
   localparam int SMAG_W = TAN_W;
   localparam int H_W    = VAL_W;
   localparam int W_W    = H_W + 2;
   localparam int K_W    = W_W + 1;
   localparam int PROD_W = SMAG_W + K_W;
   localparam int DEN_W  = SMAG_W + W_W + 1;
   localparam int NUM_W  = 2 * SMAG_W + K_W;

   // divider widths: quotient bits cover both the secant and the mean
   localparam int QW     = (TAN_W > VAL_W + FRAC_BITS) ? TAN_W : VAL_W + FRAC_BITS;
   localparam int REM_W  = DEN_W + 1;
   localparam int QCNT_W = $clog2(QW + 1);

   localparam int NUM_CHUNKS = (PROD_W + K_W - 1) / K_W;
   localparam int SHIFT_W    = $clog2(NUM_CHUNKS);

   // multiply sequence steps
   localparam int MS_P     = 0;
   localparam int MS_PCAP  = 2;
   localparam int MS_DEN1  = 3;
   localparam int MS_DCAP  = 5;
   localparam int MS_NUM0  = MS_DCAP;
   localparam int MS_START = MS_NUM0 + NUM_CHUNKS + 1;
   localparam int STEP_W   = $clog2(MS_START + 1);

   localparam logic [TAN_W-1:0] TAN_MAX_U = {1'b0, {(TAN_W-1){1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEC,
      ST_TAN,
      ST_MUL,
      ST_DIV,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   typedef struct packed {
      logic               issue;
      logic               clear;
      logic [SHIFT_W-1:0] chunk;
   } mac_ctl_type;

   typedef struct packed {
      logic ld_den;
      logic start;
   } div_ctl_type;

   // Apply sign to a quotient magnitude and clamp to the tangent range.
   function automatic logic [TAN_W-1:0] sat_tan(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] tmax;
      logic [QW-1:0] tmin_mag;
      logic [QW-1:0] m;
      tmax     = QW'(TAN_MAX_U);
      tmin_mag = tmax + QW'(1);
      if (neg) begin
         m = (q > tmin_mag) ? tmin_mag : q;
         return TAN_W'(0) - TAN_W'(m);
      end else begin
         m = (q > tmax) ? tmax : q;
         return TAN_W'(m);
      end
   endfunction

endpackage

// ----- rtl/core/mct_if.sv -----
interface mct_req_if;
   logic                          valid;
   logic                          ready;
   logic [mct_pkg::VAL_W-1:0]     point_time;
   logic [mct_pkg::VAL_W-1:0]     point_value;
   logic                          last_point;

   modport source (output valid, output point_time, output point_value, output last_point,
                   input ready);
   modport sink   (input valid, input point_time, input point_value, input last_point,
                   output ready);
endinterface

interface mct_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mct_pkg::IDX_W-1:0]        point_index;
   logic signed [mct_pkg::TAN_W-1:0] tangent;
   logic                             last_result;

   modport source (output valid, output point_index, output tangent, output last_result,
                   input ready);
   modport sink   (input valid, input point_index, input tangent, input last_result,
                   output ready);
endinterface

// ----- rtl/core/monotone_cubic_tangents.sv -----
// Monotone cubic (PCHIP) tangent generator. Contour points stream in on req_ch as
// (point_time, point_value) in unsigned Q1.16 with last_point on the final beat;
// tangents stream out on rsp_ch in signed Q.16, one beat per point, in point order,
// with last_result on the final one. The first point of a contour gives no beat, each
// later point gives the tangent of the point before it, and the last point also gives
// its own, so a beat lags its point by one. A one-point contour gives tangent 0. Point
// number 255 closes the contour even without last_point. Secant slopes and the
// span-weighted harmonic mean for interior points both run on one radix-2 restoring
// divider that retires one quotient bit per cycle (34 bits per division), fed by one
// registered 34x20 multiply-accumulate unit. A later point whose time does not rise
// skips the divider. Any other later point runs the divider once for its secant when
// its tangent is an endpoint slope or is flat, and then the multiply sequence and the
// divider again when the weighted mean is needed. A closing point emits its own beat
// from a second emit state, and a stalled receiver holds either emit state. req_ch
// is ready only between points, and a finished beat waits in the output register
// while the next point is taken.
`include "monotone_cubic_tangents_defines.svh"

module monotone_cubic_tangents (
   input  logic       clock,
   input  logic       reset,
   mct_req_if.sink    req_ch,
   mct_rsp_if.source  rsp_ch
);

   // contour state
   mct_pkg::state_type           state_ff,      state_in;
   logic [mct_pkg::CNT_W-1:0]    count_ff,      count_in;
   logic [mct_pkg::VAL_W-1:0]    prev_time_ff,  prev_time_in;
   logic [mct_pkg::VAL_W-1:0]    prev_value_ff, prev_value_in;
   logic [mct_pkg::SPAN_W-1:0]   prev_span_ff,  prev_span_in;
   logic [mct_pkg::TAN_W-1:0]    prev_slope_ff, prev_slope_in;

   // current point
   logic [mct_pkg::VAL_W-1:0]    t_ff,     t_in;
   logic [mct_pkg::VAL_W-1:0]    v_ff,     v_in;
   logic                         last_ff,  last_in;
   logic [mct_pkg::SPAN_W-1:0]   span_ff,  span_in;
   logic                         neg_ff,   neg_in;
   logic [mct_pkg::TAN_W-1:0]    slope_ff, slope_in;
   logic [mct_pkg::TAN_W-1:0]    tan_ff,   tan_in;
   logic [mct_pkg::STEP_W-1:0]   step_ff,  step_in;
   logic [mct_pkg::PROD_W-1:0]   p_ff,     p_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mct_pkg::IDX_W-1:0]    rsp_idx_ff,   rsp_idx_in;
   logic [mct_pkg::TAN_W-1:0]    rsp_tan_ff,   rsp_tan_in;
   logic                         rsp_last_ff,  rsp_last_in;

   // shared units
   mct_pkg::mac_ctl_type         mac_ctl;
   logic [mct_pkg::SMAG_W-1:0]   mac_a;
   logic [mct_pkg::K_W-1:0]      mac_b;
   logic [mct_pkg::NUM_W-1:0]    mac_acc;
   mct_pkg::div_ctl_type         div_ctl;
   logic [mct_pkg::NUM_W-1:0]    div_num;
   logic [mct_pkg::DEN_W-1:0]    div_den;
   logic                         div_done;
   logic [mct_pkg::QW-1:0]       div_quo;

   // helpers
   logic                         rsp_free;
   logic                         out_load;
   logic                         out_last;
   logic                         force_last;
   logic [mct_pkg::SPAN_W-1:0]   span_new;
   logic [mct_pkg::SPAN_W-1:0]   diff_new;
   logic [mct_pkg::SPAN_W-1:0]   diff_abs;
   logic                         span_pos;
   logic [mct_pkg::SMAG_W-1:0]   ua;
   logic [mct_pkg::SMAG_W-1:0]   ub;
   logic [mct_pkg::W_W-1:0]      w1;
   logic [mct_pkg::W_W-1:0]      w2;
   logic [mct_pkg::K_W-1:0]      wsum;
   logic                         flat;
   logic [mct_pkg::NUM_CHUNKS*mct_pkg::K_W-1:0] p_ext;
   logic [mct_pkg::SHIFT_W-1:0]  chunk_idx;

   mct_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   mct_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Point arithmetic that feeds the sequencer.
   always_comb begin
      span_new = mct_pkg::SPAN_W'(req_ch.point_time) - mct_pkg::SPAN_W'(prev_time_ff);
      diff_new = mct_pkg::SPAN_W'(req_ch.point_value) - mct_pkg::SPAN_W'(prev_value_ff);
      diff_abs = diff_new[mct_pkg::SPAN_W-1] ? (~diff_new + mct_pkg::SPAN_W'(1)) : diff_new;
      span_pos = !span_new[mct_pkg::SPAN_W-1] && (span_new != '0);
      force_last = count_ff >= mct_pkg::CNT_W'(mct_pkg::MAX_POINTS - 1);

      // slope magnitudes and span weights for the interior mean
      ua = prev_slope_ff[mct_pkg::TAN_W-1] ? (~prev_slope_ff + mct_pkg::TAN_W'(1))
                                            : prev_slope_ff;
      ub = slope_ff[mct_pkg::TAN_W-1] ? (~slope_ff + mct_pkg::TAN_W'(1)) : slope_ff;
      w1 = mct_pkg::W_W'({span_ff[mct_pkg::H_W-1:0], 1'b0})
         + mct_pkg::W_W'(prev_span_ff[mct_pkg::H_W-1:0]);
      w2 = mct_pkg::W_W'(span_ff[mct_pkg::H_W-1:0])
         + mct_pkg::W_W'({prev_span_ff[mct_pkg::H_W-1:0], 1'b0});
      wsum = mct_pkg::K_W'(w1) + mct_pkg::K_W'(w2);

      // flat when a slope is zero, the signs differ, or a span is not positive
      flat = (prev_slope_ff == '0) || (slope_ff == '0)
          || (prev_slope_ff[mct_pkg::TAN_W-1] != slope_ff[mct_pkg::TAN_W-1])
          || prev_span_ff[mct_pkg::SPAN_W-1] || (prev_span_ff == '0)
          || span_ff[mct_pkg::SPAN_W-1] || (span_ff == '0);

      p_ext     = (mct_pkg::NUM_CHUNKS*mct_pkg::K_W)'(p_ff);
      chunk_idx = mct_pkg::SHIFT_W'(step_ff - mct_pkg::STEP_W'(mct_pkg::MS_NUM0));
   end

   // Sequencer: next state, shared-unit commands and output loads.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      prev_time_in  = prev_time_ff;
      prev_value_in = prev_value_ff;
      prev_span_in  = prev_span_ff;
      prev_slope_in = prev_slope_ff;
      t_in          = t_ff;
      v_in          = v_ff;
      last_in       = last_ff;
      span_in       = span_ff;
      neg_in        = neg_ff;
      slope_in      = slope_ff;
      tan_in        = tan_ff;
      step_in       = step_ff;
      p_in          = p_ff;

      mac_ctl  = '0;
      mac_a    = '0;
      mac_b    = '0;
      div_ctl  = '0;
      div_num  = '0;
      div_den  = '0;
      out_load = 1'b0;
      out_last = 1'b0;
      rsp_idx_in = rsp_idx_ff;
      rsp_tan_in = rsp_tan_ff;

      rsp_free = !rsp_valid_ff || rsp_ch.ready;

      unique case (state_ff)
         mct_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               t_in     = req_ch.point_time;
               v_in     = req_ch.point_value;
               last_in  = req_ch.last_point || force_last;
               span_in  = span_new;
               neg_in   = diff_new[mct_pkg::SPAN_W-1];
               slope_in = '0;
               if (count_ff == '0) begin
                  if (req_ch.last_point || force_last) begin
                     state_in = mct_pkg::ST_EMIT_B;
                  end else begin
                     // open the contour
                     prev_time_in  = req_ch.point_time;
                     prev_value_in = req_ch.point_value;
                     prev_span_in  = '0;
                     prev_slope_in = '0;
                     count_in      = mct_pkg::CNT_W'(1);
                  end
               end else if (span_pos) begin
                  // secant: |dv| << FRAC_BITS over the span
                  div_ctl  = '{ld_den: 1'b1, start: 1'b1};
                  div_num  = mct_pkg::NUM_W'({diff_abs[mct_pkg::VAL_W-1:0],
                                             {mct_pkg::FRAC_BITS{1'b0}}});
                  div_den  = mct_pkg::DEN_W'(span_new[mct_pkg::VAL_W-1:0]);
                  state_in = mct_pkg::ST_SEC;
               end else begin
                  state_in = mct_pkg::ST_TAN;
               end
            end
         end

         mct_pkg::ST_SEC: begin
            if (div_done) begin
               slope_in = mct_pkg::sat_tan(div_quo, neg_ff);
               state_in = mct_pkg::ST_TAN;
            end
         end

         mct_pkg::ST_TAN: begin
            priority if (count_ff == mct_pkg::CNT_W'(1)) begin
               tan_in   = slope_ff;
               state_in = mct_pkg::ST_EMIT_A;
            end else if (flat) begin
               tan_in   = '0;
               state_in = mct_pkg::ST_EMIT_A;
            end else begin
               step_in  = '0;
               state_in = mct_pkg::ST_MUL;
            end
         end

         mct_pkg::ST_MUL: begin
            // build p = |b|*(w1+w2), den = w1*|b| + w2*|a|, num = |a|*p
            step_in = step_ff + mct_pkg::STEP_W'(1);
            priority if (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_P)) begin
               mac_ctl = '{issue: 1'b1, clear: 1'b1, chunk: '0};
               mac_a   = ub;
               mac_b   = wsum;
            end else if (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_PCAP)) begin
               p_in    = mac_acc[mct_pkg::PROD_W-1:0];
               mac_ctl = '{issue: 1'b1, clear: 1'b1, chunk: '0};
               mac_a   = ub;
               mac_b   = mct_pkg::K_W'(w1);
            end else if (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_DEN1)) begin
               mac_ctl = '{issue: 1'b1, clear: 1'b0, chunk: '0};
               mac_a   = ua;
               mac_b   = mct_pkg::K_W'(w2);
            end else if (step_ff >= mct_pkg::STEP_W'(mct_pkg::MS_NUM0)
                      && step_ff <  mct_pkg::STEP_W'(mct_pkg::MS_NUM0 + mct_pkg::NUM_CHUNKS)) begin
               if (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_DCAP)) begin
                  div_ctl.ld_den = 1'b1;
                  div_den        = mac_acc[mct_pkg::DEN_W-1:0];
               end
               mac_ctl = '{issue: 1'b1,
                           clear: (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_NUM0)),
                           chunk: chunk_idx};
               mac_a   = ua;
               mac_b   = p_ext[int'(chunk_idx)*mct_pkg::K_W +: mct_pkg::K_W];
            end else if (step_ff == mct_pkg::STEP_W'(mct_pkg::MS_START)) begin
               div_ctl.start = 1'b1;
               div_num       = mac_acc;
               state_in      = mct_pkg::ST_DIV;
            end else begin
               // pipeline drain cycles
               mac_ctl = '0;
            end
         end

         mct_pkg::ST_DIV: begin
            if (div_done) begin
               tan_in   = mct_pkg::sat_tan(div_quo, prev_slope_ff[mct_pkg::TAN_W-1]);
               state_in = mct_pkg::ST_EMIT_A;
            end
         end

         mct_pkg::ST_EMIT_A: begin
            // tangent of the previous point
            if (rsp_free) begin
               out_load   = 1'b1;
               rsp_idx_in = mct_pkg::IDX_W'(count_ff - mct_pkg::CNT_W'(1));
               rsp_tan_in = tan_ff;
               if (last_ff) begin
                  state_in = mct_pkg::ST_EMIT_B;
               end else begin
                  prev_time_in  = t_ff;
                  prev_value_in = v_ff;
                  prev_span_in  = span_ff;
                  prev_slope_in = slope_ff;
                  count_in      = count_ff + mct_pkg::CNT_W'(1);
                  state_in      = mct_pkg::ST_IDLE;
               end
            end
         end

         mct_pkg::ST_EMIT_B: begin
            // closing point takes the final slope; then drop the contour
            if (rsp_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               rsp_idx_in    = mct_pkg::IDX_W'(count_ff);
               rsp_tan_in    = slope_ff;
               prev_time_in  = '0;
               prev_value_in = '0;
               prev_span_in  = '0;
               prev_slope_in = '0;
               count_in      = '0;
               state_in      = mct_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mct_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      rsp_last_in  = out_load ? out_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mct_pkg::ST_IDLE;
         count_ff      <= '0;
         prev_time_ff  <= '0;
         prev_value_ff <= '0;
         prev_span_ff  <= '0;
         prev_slope_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_time_ff  <= prev_time_in;
         prev_value_ff <= prev_value_in;
         prev_span_ff  <= prev_span_in;
         prev_slope_ff <= prev_slope_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      t_ff        <= t_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      span_ff     <= span_in;
      neg_ff      <= neg_in;
      slope_ff    <= slope_in;
      tan_ff      <= tan_in;
      step_ff     <= step_in;
      p_ff        <= p_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_tan_ff  <= rsp_tan_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready       = (state_ff == mct_pkg::ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.point_index = rsp_idx_ff;
   assign rsp_ch.tangent     = rsp_tan_ff;
   assign rsp_ch.last_result = rsp_last_ff;

   `MCT_ASSERT(a_no_overwrite, out_load |-> (!rsp_valid_ff || rsp_ch.ready), "output beat overwritten while stalled")
   `MCT_ASSERT_ALWAYS(a_reset_clears, reset |=> (count_ff == '0 && !rsp_valid_ff && state_ff == mct_pkg::ST_IDLE), "reset left contour state behind")
   `MCT_ASSERT(a_last_ends, (out_load && out_last) |=> (count_ff == '0), "contour not closed after final tangent")
   `MCT_ASSERT(a_div_owner, div_done |-> (state_ff == mct_pkg::ST_SEC || state_ff == mct_pkg::ST_DIV), "divider finished with no waiting step")
   `MCT_ASSERT(a_mean_bounded, (state_ff == mct_pkg::ST_DIV && div_done) |-> (div_quo <= mct_pkg::QW'(ua) || div_quo <= mct_pkg::QW'(ub)), "weighted mean above both slopes")

endmodule

// ----- rtl/core/mct_mac.sv -----
module mct_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  mct_pkg::mac_ctl_type       ctl,
   input  logic [mct_pkg::SMAG_W-1:0] op_a,
   input  logic [mct_pkg::K_W-1:0]    op_b,
   output logic [mct_pkg::NUM_W-1:0]  acc
);

   logic [mct_pkg::PROD_W-1:0] prod_ff;
   mct_pkg::mac_ctl_type       ctl_ff;
   logic [mct_pkg::NUM_W-1:0]  acc_ff;
   logic [mct_pkg::NUM_W-1:0]  addend;
   logic [mct_pkg::NUM_W-1:0]  acc_in;

   // align the partial product to its chunk, then clear or add
   always_comb begin
      addend = mct_pkg::NUM_W'(prod_ff) << (mct_pkg::K_W * int'(ctl_ff.chunk));
      acc_in = ctl_ff.clear ? addend : acc_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      if (ctl.issue) begin
         prod_ff <= op_a * op_b;
      end
      if (ctl_ff.issue) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/core/mct_div.sv -----
module mct_div (
   input  logic                      clock,
   input  logic                      reset,
   input  mct_pkg::div_ctl_type      ctl,
   input  logic [mct_pkg::NUM_W-1:0] num,
   input  logic [mct_pkg::DEN_W-1:0] den,
   output logic                      done,
   output logic [mct_pkg::QW-1:0]    quo
);

   logic [mct_pkg::DEN_W-1:0]  den_ff;
   logic [mct_pkg::REM_W-1:0]  rem_ff;
   logic [mct_pkg::QW-1:0]     qn_ff;
   logic [mct_pkg::QCNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [mct_pkg::REM_W-1:0]  rem_sh;
   logic [mct_pkg::REM_W-1:0]  rem_sub;
   logic                       fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff[mct_pkg::REM_W-2:0], qn_ff[mct_pkg::QW-1]};
      rem_sub = rem_sh - mct_pkg::REM_W'(den_ff);
      fits    = rem_sh >= mct_pkg::REM_W'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mct_pkg::QCNT_W'(mct_pkg::QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - mct_pkg::QCNT_W'(1);
            if (cnt_ff == mct_pkg::QCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (ctl.ld_den) begin
         den_ff <= den;
      end
      if (ctl.start) begin
         rem_ff <= mct_pkg::REM_W'(num[mct_pkg::NUM_W-1:mct_pkg::QW]);
         qn_ff  <= num[mct_pkg::QW-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub : rem_sh;
         qn_ff  <= {qn_ff[mct_pkg::QW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = qn_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   // Quiet-cycle limit. The slowest legal gap between beats is a weighted-mean
   // point plus a receiver burst, and the deliberate receiver hold adds LONG_HOLD
   // on top of that. The margin is wide.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int LONG_HOLD      = 300;
   localparam int POINT_FULL     = 65536;   // 1.0 in Q1.16

   typedef logic [mct_pkg::VAL_W-1:0] point_word_type;

   typedef struct packed {
      logic [mct_pkg::IDX_W-1:0] index;
      logic [mct_pkg::TAN_W-1:0] tangent;
      logic                      last;
   } tangent_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mct_req_if req_ch ();
   mct_rsp_if rsp_ch ();

   monotone_cubic_tangents dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Contour tracker: mirrors what the block remembers between points.
   point_word_type   anchor_time    = '0;
   point_word_type   anchor_value   = '0;
   int               anchor_span    = 0;
   longint           anchor_slope   = 0;
   int               contour_points = 0;
   tangent_beat_type pending_tangents[$];

   bit sender_bursts   = 1'b1;
   bit receiver_bursts = 1'b1;
   int hold_requests   = 0;
   int holds_taken     = 0;
   int receiver_hold   = 0;
   int points_sent     = 0;
   int mismatch_count  = 0;
   int quiet_cycles    = 0;

   // Secant slope in Q.16. It is truncated toward zero and is flat when the
   // span is not positive. Its magnitude never exceeds 2^32, so no clamp is
   // needed.
   function automatic longint secant_slope(int diff, int span);
      longint mag;
      if (span <= 0)
         return 0;
      mag = (diff < 0) ? -diff : diff;
      mag = (mag <<< mct_pkg::FRAC_BITS) / span;
      return (diff < 0) ? -mag : mag;
   endfunction

   // Span-weighted harmonic mean of the two neighboring slopes. It is flat on a
   // zero slope, a sign change or a span that is not positive. The products are
   // exact and there is a single truncating divide.
   function automatic longint harmonic_tangent(longint a, longint b, int h1, int h2);
      logic [127:0] ua, ub, w1, w2, num, den, q, cap;
      longint       mag;
      if (a == 0 || b == 0 || ((a < 0) != (b < 0)) || h1 <= 0 || h2 <= 0)
         return 0;
      ua  = 128'((a < 0) ? -a : a);
      ub  = 128'((b < 0) ? -b : b);
      w1  = 128'(2 * h2 + h1);
      w2  = 128'(h2 + 2 * h1);
      num = ua * ub * (w1 + w2);
      den = w1 * ub + w2 * ua;
      q   = num / den;
      // clamp the magnitude so the signed 34-bit range holds
      cap = (a < 0) ? 128'(mct_pkg::TAN_MAX_U) + 128'd1 : 128'(mct_pkg::TAN_MAX_U);
      if (q > cap)
         q = cap;
      mag = longint'(q[63:0]);
      return (a < 0) ? -mag : mag;
   endfunction

   // Append one expected tangent beat.
   function automatic void queue_tangent(int idx, longint tan, logic lst);
      tangent_beat_type beat;
      beat.index   = mct_pkg::IDX_W'(idx);
      beat.tangent = mct_pkg::TAN_W'(tan);
      beat.last    = lst;
      pending_tangents.insert(pending_tangents.size(), beat);
   endfunction

   // Advance the contour by one accepted point and queue the tangents it releases.
   function automatic void compute_tangents(point_word_type t, point_word_type v, logic lst);
      int     n;
      int     span;
      longint slope;
      longint tan;
      bit     closing;
      n       = contour_points;
      closing = lst || (n >= mct_pkg::MAX_POINTS - 1);
      if (n == 0) begin
         if (closing)
            queue_tangent(0, 0, 1'b1);
         else begin
            anchor_time    = t;
            anchor_value   = v;
            anchor_span    = 0;
            anchor_slope   = 0;
            contour_points = 1;
         end
         return;
      end
      span  = int'(t) - int'(anchor_time);
      slope = secant_slope(int'(v) - int'(anchor_value), span);
      tan   = (n == 1) ? slope : harmonic_tangent(anchor_slope, slope, anchor_span, span);
      queue_tangent(n - 1, tan, 1'b0);
      if (closing) begin
         queue_tangent(n, slope, 1'b1);
         anchor_time    = '0;
         anchor_value   = '0;
         anchor_span    = 0;
         anchor_slope   = 0;
         contour_points = 0;
      end else begin
         anchor_time    = t;
         anchor_value   = v;
         anchor_span    = span;
         anchor_slope   = slope;
         contour_points = n + 1;
      end
   endfunction

   // Offer one point. Optionally drop valid for a burst first, then hold the
   // beat until the block takes it. Valid stays high on return so that
   // back-to-back points never lower and raise it in one step.
   task automatic send_point(int t, int v, logic lst);
      if (sender_bursts && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.point_time  <= mct_pkg::VAL_W'(t);
      req_ch.point_value <= mct_pkg::VAL_W'(v);
      req_ch.last_point  <= lst;
      do
         @(posedge clock);
      while (!req_ch.ready);
      compute_tangents(mct_pkg::VAL_W'(t), mct_pkg::VAL_W'(v), lst);
      points_sent++;
   endtask

   function automatic int pick_level();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return POINT_FULL;
         default: return $urandom_range(0, POINT_FULL);
      endcase
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0:          return 1;
         7, 8:       return $urandom_range(7, 20);
         9:          return $urandom_range(21, 60);
         default:    return $urandom_range(2, 6);
      endcase
   endfunction

   // Send one contour. A tidy contour has strictly rising times and values that
   // drift in one direction with occasional jumps, so interior points reach the
   // weighted mean. An untidy one has random times, levels and end marks.
   task automatic send_contour(int len, bit tidy, bit mark_end);
      int t;
      int v;
      int step_cap;
      int drift;
      t        = $urandom_range(0, POINT_FULL - len);
      step_cap = (POINT_FULL - t) / len;
      // short steps give the steepest slopes
      if ($urandom_range(0, 3) == 0 && step_cap > 4)
         step_cap = 4;
      v     = pick_level();
      drift = ($urandom_range(0, 1) == 1) ? 1 : -1;
      for (int i = 0; i < len; i++) begin
         if (!tidy) begin
            t = $urandom_range(0, POINT_FULL);
            v = pick_level();
            send_point(t, v, $urandom_range(0, 1) == 1);
         end else begin
            if (i > 0)
               t += $urandom_range(1, step_cap);
            if ($urandom_range(0, 3) == 0)
               v = pick_level();
            else
               v += drift * int'($urandom_range(0, 4096));
            if (v < 0)
               v = 0;
            if (v > POINT_FULL)
               v = POINT_FULL;
            send_point(t, v, mark_end && (i == len - 1));
         end
      end
   endtask

   // One-point contours at both corners of the 0 to 1.0 range.
   task automatic test_single_points();
      send_point(0, 0, 1'b1);
      send_point(POINT_FULL, POINT_FULL, 1'b1);
   endtask

   // Unit spans with a full swing give the largest slope magnitudes. Unequal
   // spans weight the mean.
   task automatic test_steep_slopes();
      send_point(0, 0, 1'b0);
      send_point(1, 32768, 1'b0);
      send_point(2, POINT_FULL, 1'b1);
      send_point(0, POINT_FULL, 1'b0);
      send_point(1, 32768, 1'b0);
      send_point(POINT_FULL, 0, 1'b1);
      send_point(65535, 0, 1'b0);
      send_point(POINT_FULL, POINT_FULL, 1'b1);
   endtask

   // Peak, flat run and restart: sign change and zero slope both flatten.
   task automatic test_flat_and_turning();
      send_point(100, 0, 1'b0);
      send_point(200, POINT_FULL, 1'b0);
      send_point(300, 0, 1'b0);
      send_point(400, 0, 1'b0);
      send_point(500, 100, 1'b1);
   endtask

   // Repeated and falling times: zero and negative spans give flat slopes.
   task automatic test_bad_spans();
      send_point(1000, 10, 1'b0);
      send_point(1000, 500, 1'b0);
      send_point(900, 20, 1'b0);
      send_point(2000, 30, 1'b1);
   endtask

   // Full-length contours. The first never marks its end and must close on the
   // point-count limit. The second marks the end on that same point.
   task automatic test_point_limit();
      send_contour(mct_pkg::MAX_POINTS, 1'b1, 1'b0);
      send_contour(mct_pkg::MAX_POINTS, 1'b1, 1'b1);
      send_contour(3, 1'b1, 1'b1);
   endtask

   // Hold the receiver off for a long stretch while points keep coming, so the
   // output register fills and the input stalls.
   task automatic test_receiver_stall();
      hold_requests++;
      repeat (5)
         send_contour(pick_length(), 1'b1, 1'b1);
   endtask

   // Mostly tidy contours with random content, with some noise mixed in.
   task automatic test_random_contours(int target);
      while (points_sent < target)
         send_contour(pick_length(), $urandom_range(0, 6) != 0, 1'b1);
   endtask

   // Drop all idling for the closing stretch and run back to back.
   task automatic test_steady_stream(int count);
      int start;
      start           = points_sent;
      sender_bursts   = 1'b0;
      receiver_bursts = 1'b0;
      while (points_sent - start < count)
         send_contour(pick_length(), 1'b1, 1'b1);
   endtask

   // Receiver: random ready bursts, plus the long hold requested by a test.
   always @(posedge clock) begin
      if (holds_taken != hold_requests) begin
         receiver_hold = LONG_HOLD;
         holds_taken   = hold_requests;
      end
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (receiver_hold > 0) begin
         receiver_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (receiver_bursts && $urandom_range(0, 5) == 0) begin
         receiver_hold = $urandom_range(1, 12) - 1;
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= 1'b1;
   end

   // Check each accepted tangent beat against the oldest pending one.
   always @(posedge clock) begin
      tangent_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_tangents.size() == 0) begin
            $error("tangent beat with nothing pending: point_index %0d tangent %0d",
                   rsp_ch.point_index, rsp_ch.tangent);
            mismatch_count++;
         end else begin
            want = pending_tangents.pop_front();
            if (rsp_ch.point_index !== want.index) begin
               $error("point_index: expected %0d, got %0d", want.index, rsp_ch.point_index);
               mismatch_count++;
            end
            if (rsp_ch.tangent !== want.tangent) begin
               $error("tangent: expected %0d, got %0d", $signed(want.tangent),
                      rsp_ch.tangent);
               mismatch_count++;
            end
            if (rsp_ch.last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_ch.last_result);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.point_time  = '0;
      req_ch.point_value = '0;
      req_ch.last_point  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_single_points();
      test_steep_slopes();
      test_flat_and_turning();
      test_bad_spans();
      test_point_limit();
      test_receiver_stall();
      test_random_contours(1700);
      test_steady_stream(200);

      // Drop valid, drain what is pending, then let any stray beat show up.
      req_ch.valid <= 1'b0;
      while (pending_tangents.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
